/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion with asynchronous active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

/* sv/itwa_pkg.sv */
`timescale 1ns / 1ps
package itwa_pkg;
  localparam int unsigned NumAxes = 6;
  localparam int unsigned AxisW   = 32;
  localparam int unsigned SumW    = 48;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned CntW    = 9;
  localparam int unsigned WinW    = 48;
  localparam int unsigned EntryW  = 1 + NumAxes * AxisW;

  typedef enum logic {
    MODE_ADD   = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef enum logic [0:0] {
    REG_MAX_ENTRIES = 1'b0,
    REG_WINDOW_NS   = 1'b1
  } reg_idx_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_item;    // latch incoming item
    logic write_entry;  // write item into store at tail
    logic push;         // occupancy++
    logic pop;          // drop oldest
    logic rd_time;      // issue read of head time
    logic rd_entry;     // issue read at walk pointer
    logic acc_clear;    // clear sums and walk pointer
    logic acc_add;      // accumulate read data
    logic walk_step;    // advance walk pointer
    logic div_start;    // start dividers
    logic out_load;     // load result register
  } itwa_cmd_t;

  typedef struct packed {
    logic is_query;
    logic full;         // occupancy >= depth
    logic over_limit;   // occupancy > limit
    logic empty;
    logic head_old;     // head time below threshold
    logic walk_done;    // walk pointer reached occupancy
    logic div_done;
    logic out_busy;     // result register still held
  } itwa_sts_t;
endpackage

/* sv/itwa_ram.sv */
`timescale 1ns / 1ps
module itwa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* sv/itwa_div.sv */
`timescale 1ns / 1ps
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
module itwa_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [itwa_pkg::SumW-1:0]   num_i,
  input  logic [itwa_pkg::CntW-1:0]          den_i,
  output logic                               done_o,
  output logic [itwa_pkg::AxisW-1:0]         quo_o
);
  import itwa_pkg::*;
  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0]  quo_q, quo_d;
  logic [CntW:0]    rem_q, rem_d;
  logic [CntW-1:0]  den_q;
  logic             neg_q;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic [CntW:0]    trial;
  logic [SumW-1:0]  mag;

  assign mag = num_i[SumW-1] ? SumW'(-num_i) : num_i;

  always_comb begin
    trial = {rem_q[CntW-1:0], quo_q[SumW-1]};
    quo_d = {quo_q[SumW-2:0], 1'b0};
    rem_d = trial;
    if (trial >= {1'b0, den_q}) begin
      rem_d    = trial - {1'b0, den_q};
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= StepW'(SumW);
    end else if (busy_q) begin
      step_q <= step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[SumW-1];
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  logic [SumW-1:0] res;
  assign res    = neg_q ? SumW'(-quo_q) : quo_q;
  assign quo_o  = (den_q == '0) ? '0 : res[AxisW-1:0];
  assign done_o = !busy_q && !start_i;
endmodule

/* sv/itwa_datapath.sv */
`timescale 1ns / 1ps
module itwa_datapath #(
  parameter int unsigned Depth = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  itwa_pkg::itwa_cmd_t           cmd_i,
  output itwa_pkg::itwa_sts_t           sts_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [itwa_pkg::WinW-1:0]     cfg_data_i,
  input  logic [itwa_pkg::EntryW+itwa_pkg::TimeW:0] item_i,
  input  logic                          out_take_i,
  output logic [itwa_pkg::NumAxes*itwa_pkg::AxisW+itwa_pkg::CntW-1:0] out_o
);
  import itwa_pkg::*;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned OccW  = $clog2(Depth + 1);
  localparam int unsigned PtrW  = AddrW + 1;

  logic [CntW-1:0]    max_q;
  logic [WinW-1:0]    win_q;
  logic [AddrW-1:0]   head_q;
  logic [OccW-1:0]    occ_q, walk_q;
  logic               mode_q;
  logic [TimeW-1:0]   now_q;
  logic [EntryW-1:0]  ent_q;
  logic [TimeW-1:0]   thr_q;
  logic [TimeW-1:0]   rtime;
  logic [EntryW-1:0]  rent;
  logic signed [SumW-1:0] sum_q [NumAxes];
  logic [CntW-1:0]    cnt_q;
  logic [NumAxes-1:0] ddone;
  logic [AxisW-1:0]   quo [NumAxes];
  logic               out_busy_q;
  logic [NumAxes*AxisW+CntW-1:0] out_q;
  logic [AddrW-1:0]   tail, raddr;
  logic [OccW-1:0]    limit;

  // circular pointer add, wraps at Depth (off never exceeds Depth)
  function automatic logic [AddrW-1:0] wrap_add(input logic [AddrW-1:0] base,
                                                input logic [OccW-1:0] off);
    logic [PtrW-1:0] s;
    s = PtrW'(base) + PtrW'(off);
    if (s >= PtrW'(Depth)) s = s - PtrW'(Depth);
    return s[AddrW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= CntW'(256);
      win_q <= WinW'(64'd1000000000);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_MAX_ENTRIES) max_q <= cfg_data_i[CntW-1:0];
      else                              win_q <= cfg_data_i;
    end
  end

  assign limit = ({{(32-CntW){1'b0}}, max_q} > 32'(Depth)) ? OccW'(Depth)
                                                             : OccW'(max_q);
  assign tail  = wrap_add(head_q, occ_q);
  assign raddr = cmd_i.rd_time ? head_q : wrap_add(head_q, walk_q);

  itwa_ram #(.Width(TimeW), .Depth(Depth)) u_time (
    .clk_i, .we_i(cmd_i.write_entry), .waddr_i(tail), .wdata_i(now_q),
    .raddr_i(raddr), .rdata_o(rtime));
  itwa_ram #(.Width(EntryW), .Depth(Depth)) u_ent (
    .clk_i, .we_i(cmd_i.write_entry), .waddr_i(tail), .wdata_i(ent_q),
    .raddr_i(raddr), .rdata_o(rent));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q <= item_i[0];
      now_q  <= item_i[TimeW:1];
      ent_q  <= item_i[EntryW+TimeW:TimeW+1];
      thr_q  <= (item_i[TimeW:1] > {16'd0, win_q})
                ? item_i[TimeW:1] - {16'd0, win_q} : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      occ_q  <= '0;
    end else if (cmd_i.push) begin
      occ_q <= occ_q + OccW'(1);
    end else if (cmd_i.pop) begin
      head_q <= wrap_add(head_q, OccW'(1));
      occ_q  <= occ_q - OccW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clear) begin
      walk_q <= '0;
      cnt_q  <= '0;
      for (int k = 0; k < NumAxes; k++) sum_q[k] <= '0;
    end else begin
      if (cmd_i.walk_step) walk_q <= walk_q + OccW'(1);
      if (cmd_i.acc_add && rent[0]) begin
        cnt_q <= cnt_q + CntW'(1);
        for (int k = 0; k < NumAxes; k++) begin
          sum_q[k] <= sum_q[k] + SumW'($signed(rent[1+k*AxisW +: AxisW]));
        end
      end
    end
  end

  for (genvar g = 0; g < NumAxes; g++) begin : g_div
    itwa_div u_div (
      .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(sum_q[g]),
      .den_i(cnt_q), .done_o(ddone[g]), .quo_o(quo[g]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_busy_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_busy_q <= 1'b1;
    end else if (out_take_i) begin
      out_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {cnt_q, quo[5], quo[4], quo[3], quo[2], quo[1], quo[0]};
    end
  end

  assign out_o = out_q;
  assign sts_o.is_query   = mode_q;
  assign sts_o.full       = occ_q >= OccW'(Depth);
  assign sts_o.over_limit = occ_q > limit;
  assign sts_o.empty      = occ_q == '0;
  assign sts_o.head_old   = rtime < thr_q;
  assign sts_o.walk_done  = walk_q == occ_q;
  assign sts_o.div_done   = &ddone;
  assign sts_o.out_busy   = out_busy_q;
endmodule

/* sv/itwa_ctrl.sv */
`timescale 1ns / 1ps
module itwa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_fire_i,
  output logic                in_ready_o,
  input  itwa_pkg::itwa_sts_t sts_i,
  output itwa_pkg::itwa_cmd_t cmd_o
);
  import itwa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ADD_TRIM, S_ADD_WRITE, S_ADD_LIMIT,
    S_Q_RD, S_Q_WAIT, S_Q_CHK, S_W_RD, S_W_WAIT, S_W_ACC,
    S_DIV, S_DIV_WAIT, S_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: state_d = sts_i.is_query ? S_Q_RD : S_ADD_TRIM;
      S_ADD_TRIM: begin
        if (sts_i.full) cmd_o.pop = 1'b1;
        state_d = S_ADD_WRITE;
      end
      S_ADD_WRITE: begin
        cmd_o.write_entry = 1'b1;
        cmd_o.push = 1'b1;
        state_d = S_ADD_LIMIT;
      end
      S_ADD_LIMIT: begin
        if (sts_i.over_limit) cmd_o.pop = 1'b1;
        else state_d = S_IDLE;
      end
      S_Q_RD: begin
        cmd_o.rd_time = 1'b1;
        state_d = sts_i.empty ? S_W_RD : S_Q_WAIT;
        cmd_o.acc_clear = sts_i.empty;
      end
      // keep the head address on the read port until the compare
      S_Q_WAIT: begin
        cmd_o.rd_time = 1'b1;
        state_d = S_Q_CHK;
      end
      S_Q_CHK: begin
        if (sts_i.head_old) begin
          cmd_o.pop = 1'b1;
          state_d = S_Q_RD;
        end else begin
          cmd_o.acc_clear = 1'b1;
          state_d = S_W_RD;
        end
      end
      S_W_RD: begin
        if (sts_i.walk_done) begin
          state_d = S_DIV;
        end else begin
          cmd_o.rd_entry = 1'b1;
          state_d = S_W_WAIT;
        end
      end
      S_W_WAIT: state_d = S_W_ACC;
      S_W_ACC: begin
        cmd_o.acc_add = 1'b1;
        cmd_o.walk_step = 1'b1;
        state_d = S_W_RD;
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: if (sts_i.div_done) state_d = S_OUT;
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_o <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_ready_o <= (state_d == S_IDLE) && !(in_fire_i && state_q == S_IDLE);
    end
  end
endmodule

/* sv/imu_time_window_average_unit.sv */
`timescale 1ns / 1ps
// IMU time-window averaging unit.
// Input stream s_axis: one item per add (tuser=0) or query (tuser=1).
//   An add stores a timestamped sample in a circular window of DEPTH
//   entries and trims it to max_entries; it returns nothing.
//   A query drops entries older than time_ns - window_ns, then averages
//   the calibrated entries per axis and returns one item on m_axis.
// Config: cfg_we_i/cfg_idx_i/cfg_data_i; index 0 max_entries, 1 window_ns.
//   Write only while idle.
// Sequence: an add pops the oldest entry if the window is full, writes
//   the new entry, then pops the oldest while over max_entries.
//   A query reads and pops head entries older than the threshold, walks
//   each remaining entry through the single read port of the sample
//   memory, then runs six serial dividers (one quotient bit per cycle).
// One item is in work at a time. The result register holds a finished
//   item while the receiver stalls; the next query waits for it to drain.
// Reset empties the window and sets max_entries 256, window_ns 1e9.
module imu_time_window_average_unit #(
  parameter int unsigned DEPTH = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tuser: mode
  input  logic         s_axis_tuser,
  // tdata: time_ns[63:0], has_calibrated[64], accel_x/y/z, gyro_x/y/z
  //        (32 bits each from bit 65 up), zero pad to 264 bits
  input  logic [263:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: avg_accel_x/y/z, avg_gyro_x/y/z (32 each), used_count[200:192],
  //        zero pad to 208 bits
  output logic [207:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [47:0]  cfg_data_i
);
  import itwa_pkg::*;

  itwa_cmd_t cmd;
  itwa_sts_t sts;
  logic      in_fire, out_take;
  logic [NumAxes*AxisW+CntW-1:0] res;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;

  itwa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .in_ready_o(s_axis_tready),
    .sts_i(sts), .cmd_o(cmd));

  itwa_datapath #(.Depth(DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .item_i({s_axis_tdata[EntryW+TimeW-1:0], s_axis_tuser}),
    .out_take_i(out_take), .out_o(res));

  assign m_axis_tvalid = sts.out_busy;
  assign m_axis_tdata  = {7'd0, res};

`include "assert_macros.svh"
  `ASSERT_CLK(a_no_accept_busy, clk_i, rst_ni,
    in_fire |=> !s_axis_tready, "input taken while busy")
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
  `ASSERT_NEVER(a_one_cmd, clk_i, rst_ni,
    cmd.push && cmd.pop, "push and pop together")
endmodule
